>>> design/cwr_pkg.sv
`timescale 1ns / 1ps
package cwr_pkg;

	localparam int RATE_FRAC_BITS  = 24;
	localparam int COS_TABLE_DEPTH = 256;

	localparam int RATE_W   = 32;
	localparam int PERIOD_W = 31;
	localparam int GROWTH_W = 16;
	localparam int EPOCH_W  = 31;
	localparam int PROG_W   = 16;
	localparam int COS_W    = 17;
	localparam int ONE_C_W  = 18;
	localparam int FRAC_W   = 15;
	localparam int IDX_W    = $clog2(COS_TABLE_DEPTH + 1);
	localparam int CNT_W    = $clog2(EPOCH_W);
	localparam int SUB_W    = 32;
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

	typedef enum logic [1:0] {
		CFG_INITIAL_RATE  = 2'd0,
		CFG_FLOOR_RATE    = 2'd1,
		CFG_BASE_PERIOD   = 2'd2,
		CFG_PERIOD_GROWTH = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic             ge;
		logic [SUB_W-1:0] diff;
	} sub_res_t;

	typedef logic [COS_W-1:0] cos_rom_t [0:COS_TABLE_DEPTH];

	// quarter-wave cosine in q1.16 from an 11-term series in q2.30
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t    rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] c;
		for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
			x    = (HALF_PI_Q30 * 64'(i)) / COS_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = 64'd1 << 30;
			acc  = term;
			term = ((term * x2) >> 30) / 2;   acc = acc - term;
			term = ((term * x2) >> 30) / 12;  acc = acc + term;
			term = ((term * x2) >> 30) / 30;  acc = acc - term;
			term = ((term * x2) >> 30) / 56;  acc = acc + term;
			term = ((term * x2) >> 30) / 90;  acc = acc - term;
			term = ((term * x2) >> 30) / 132; acc = acc + term;
			term = ((term * x2) >> 30) / 182; acc = acc - term;
			term = ((term * x2) >> 30) / 240; acc = acc + term;
			term = ((term * x2) >> 30) / 306; acc = acc - term;
			term = ((term * x2) >> 30) / 380; acc = acc + term;
			c = acc & 64'hFFFF_FFFF;
			if (c > (64'd1 << 30)) begin
				c = 64'd1 << 30;
			end
			rom[i] = COS_W'((c + (64'd1 << 13)) >> 14);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

>>> design/cwr_query_if.sv
`timescale 1ns / 1ps
interface cwr_query_if import cwr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_number;

	modport source (output valid, output epoch_number, input ready);
	modport sink (input valid, input epoch_number, output ready);
endinterface

>>> design/cwr_answer_if.sv
`timescale 1ns / 1ps
interface cwr_answer_if import cwr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] learning_rate;
	logic              status;

	modport source (output valid, output learning_rate, output status, input ready);
	modport sink (input valid, input learning_rate, input status, output ready);
endinterface

>>> design/cwr_sub_unit.sv
`timescale 1ns / 1ps
module cwr_sub_unit import cwr_pkg::*; (
	input  logic [SUB_W-1:0] a,
	input  logic [SUB_W-1:0] b,
	output sub_res_t         res
);
	logic [SUB_W:0] full;

	// borrow out clear means a >= b
	assign full     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~full[SUB_W];
	assign res.diff = full[SUB_W-1:0];
endmodule

>>> design/cwr_mult_unit.sv
`timescale 1ns / 1ps
module cwr_mult_unit import cwr_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  product
);
	logic [PROD_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign product = product_q;
endmodule

>>> design/cosine_warm_restart_rate_unit.sv
`timescale 1ns / 1ps
// cosine annealing with warm restarts: each request carries an epoch number and
// gets back one learning rate in unsigned q8.24 plus a status bit (1 when a
// period length grows past 2^31-1 or becomes zero or the base period is zero,
// rate then 0). the block handles one request at a time through a small
// sequencer around one shared subtract/compare unit and one registered 32x18
// multiplier. with a growth of one: 31 remainder steps, 16 division steps for
// the progress, two for the cosine interpolation, two for the final scaling and
// one to hand off; otherwise a compare and a period multiply per restart passed
// and a last compare replace the remainder steps. an overflow or a zero base
// period answers early. the next request is taken in the cycle after the result
// sits in the output register; a stalled output holds the block in its hand-off
// state. configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module cosine_warm_restart_rate_unit import cwr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [RATE_W-1:0]   cfg_data,
	cwr_query_if.sink           query,
	cwr_answer_if.source        answer
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_MOD    = 10'b00_0000_0010,
		ST_SEARCH = 10'b00_0000_0100,
		ST_GROW   = 10'b00_0000_1000,
		ST_PROG   = 10'b00_0001_0000,
		ST_COS    = 10'b00_0010_0000,
		ST_INTERP = 10'b00_0100_0000,
		ST_RATE   = 10'b00_1000_0000,
		ST_FINAL  = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} state_t;

	localparam int POS_W = COS_W + IDX_W;

	// configuration registers
	logic [RATE_W-1:0]   initial_rate_q;
	logic [RATE_W-1:0]   floor_rate_q;
	logic [PERIOD_W-1:0] base_period_q;
	logic [GROWTH_W-1:0] period_growth_q;

	// sequencer and working registers
	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [PERIOD_W-1:0] t_q;
	logic [SUB_W-1:0]    r_q;
	logic [PROG_W-1:0]   p_q;
	logic                neg_q;
	logic                top_q;
	logic                a_ge_q;
	logic [COS_W-1:0]    a_q;
	logic [ONE_C_W-1:0]  c_q;
	logic                up_q;
	logic [RATE_W-1:0]   res_rate_q;
	logic                res_status_q;

	// output register
	logic                out_valid_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic                out_status_q;

	// shared units
	logic [SUB_W-1:0]    sub_a;
	logic [SUB_W-1:0]    sub_b;
	sub_res_t            sub_res;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   product;

	// cosine lookup
	logic [COS_W-1:0]    s_val;
	logic [POS_W-1:0]    pos;
	logic [POS_W-16:0]   idx;
	logic [IDX_W-1:0]    idx_lo;
	logic [FRAC_W-1:0]   frac;
	logic                idx_top;
	logic [COS_W-1:0]    rom_a;
	logic [COS_W-1:0]    rom_b;
	logic [COS_W-1:0]    rom_d;
	logic [COS_W-1:0]    corr;
	logic [COS_W-1:0]    m_val;
	logic [RATE_W-1:0]   rate_mag;
	logic [PROD_W:0]     off_full;
	logic [RATE_W-1:0]   off;

	logic                out_free;
	logic                start;

	cwr_sub_unit u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	cwr_mult_unit u_mult (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (product)
	);

	assign query.ready = (state_q == ST_IDLE);
	assign start       = query.valid && query.ready;
	assign out_free    = !out_valid_q || answer.ready;

	assign answer.valid         = out_valid_q;
	assign answer.learning_rate = out_rate_q;
	assign answer.status        = out_status_q;

	// mirror the progress into the first half wave
	assign s_val   = p_q[PROG_W-1] ? (COS_W'(1) << PROG_W) - COS_W'(p_q) : COS_W'(p_q);
	assign pos     = POS_W'(s_val) * POS_W'(COS_TABLE_DEPTH);
	assign idx     = pos[POS_W-1:FRAC_W];
	assign frac    = pos[FRAC_W-1:0];
	assign idx_top = (idx >= (POS_W-15)'(COS_TABLE_DEPTH));
	assign idx_lo  = idx_top ? IDX_W'(COS_TABLE_DEPTH - 1) : idx[IDX_W-1:0];
	assign rom_a   = COS_ROM[idx_lo];
	assign rom_b   = COS_ROM[idx_lo + IDX_W'(1)];
	assign rom_d   = (rom_a >= rom_b) ? rom_a - rom_b : rom_b - rom_a;

	// interpolation correction, rounded half up
	assign corr  = COS_W'((product + PROD_W'(16'h4000)) >> FRAC_W);
	assign m_val = top_q ? COS_ROM[COS_TABLE_DEPTH] : (a_ge_q ? a_q - corr : a_q + corr);

	assign rate_mag = sub_res.ge ? sub_res.diff : RATE_W'(0) - sub_res.diff;
	assign off_full = {1'b0, product} + (PROD_W+1)'(1 << 16);
	assign off      = off_full[RATE_W+16:17];

	// operand selection for the shared units
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MOD: begin
				sub_a = {r_q[SUB_W-2:0], epoch_q[EPOCH_W-1]};
				sub_b = SUB_W'(t_q);
			end
			ST_SEARCH: begin
				sub_a = r_q;
				sub_b = SUB_W'(t_q);
				mul_a = MUL_A_W'(t_q);
				mul_b = MUL_B_W'(period_growth_q);
			end
			ST_PROG: begin
				sub_a = {r_q[SUB_W-2:0], 1'b0};
				sub_b = SUB_W'(t_q);
			end
			ST_COS: begin
				mul_a = MUL_A_W'(rom_d);
				mul_b = MUL_B_W'(frac);
			end
			ST_RATE: begin
				sub_a = initial_rate_q;
				sub_b = floor_rate_q;
				mul_a = rate_mag;
				mul_b = c_q;
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_rate_q  <= RATE_W'(1) << RATE_FRAC_BITS;
			floor_rate_q    <= '0;
			base_period_q   <= PERIOD_W'(1);
			period_growth_q <= GROWTH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_INITIAL_RATE:  initial_rate_q  <= cfg_data;
				CFG_FLOOR_RATE:    floor_rate_q    <= cfg_data;
				CFG_BASE_PERIOD:   base_period_q   <= cfg_data[PERIOD_W-1:0];
				CFG_PERIOD_GROWTH: period_growth_q <= cfg_data[GROWTH_W-1:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						if (base_period_q == '0) begin
							state_q <= ST_DONE;
						end else if (period_growth_q == GROWTH_W'(1)) begin
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_MOD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(EPOCH_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_PROG;
					end
				end
				ST_SEARCH: begin
					state_q <= sub_res.ge ? ST_GROW : ST_PROG;
				end
				ST_GROW: begin
					if (product[PROD_W-1:PERIOD_W] != '0 || product[PERIOD_W-1:0] == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_PROG: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PROG_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COS;
					end
				end
				ST_COS:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_RATE;
				ST_RATE:   state_q <= ST_FINAL;
				ST_FINAL:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				epoch_q      <= query.epoch_number;
				t_q          <= base_period_q;
				p_q          <= '0;
				res_rate_q   <= '0;
				res_status_q <= 1'b1;
				if (period_growth_q == GROWTH_W'(1)) begin
					r_q <= '0;
				end else begin
					r_q <= SUB_W'(query.epoch_number);
				end
			end
			ST_MOD: begin
				epoch_q <= {epoch_q[EPOCH_W-2:0], 1'b0};
				r_q     <= sub_res.ge ? sub_res.diff : sub_a;
			end
			ST_SEARCH: begin
				if (sub_res.ge) begin
					r_q <= sub_res.diff;
				end
			end
			ST_GROW: begin
				t_q <= product[PERIOD_W-1:0];
			end
			ST_PROG: begin
				r_q <= sub_res.ge ? sub_res.diff : sub_a;
				p_q <= {p_q[PROG_W-2:0], sub_res.ge};
			end
			ST_COS: begin
				neg_q  <= p_q[PROG_W-1];
				top_q  <= idx_top;
				a_q    <= rom_a;
				a_ge_q <= (rom_a >= rom_b);
			end
			ST_INTERP: begin
				// 1 + cos in q2.16
				c_q <= neg_q ? (ONE_C_W'(1) << PROG_W) - ONE_C_W'(m_val)
				             : (ONE_C_W'(1) << PROG_W) + ONE_C_W'(m_val);
			end
			ST_RATE: begin
				up_q <= sub_res.ge;
			end
			ST_FINAL: begin
				res_rate_q   <= up_q ? floor_rate_q + off : floor_rate_q - off;
				res_status_q <= 1'b0;
			end
			ST_DONE: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (answer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_rate_q   <= res_rate_q;
			out_status_q <= res_status_q;
		end
	end

	// overflow answers always carry a zero rate
	a_status_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		answer.valid && answer.status |-> answer.learning_rate == '0)
		else $error("overflow status with nonzero rate");

	// the sequencer holds exactly one state
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// a finished result moves to the output only when the slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		answer.valid && !answer.ready && state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("result handed off while output stalled");

	// remainder stays below the period during the division steps
	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROG |-> r_q < SUB_W'(t_q))
		else $error("remainder not below period");

endmodule

>>> verif/cwr_rate_checker.sv
`timescale 1ns / 1ps
module cwr_rate_checker import cwr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [RATE_W-1:0] cfg_data,
	input  logic              q_valid,
	input  logic              q_ready,
	input  logic [EPOCH_W-1:0] q_epoch,
	input  logic              a_valid,
	input  logic              a_ready,
	input  logic [RATE_W-1:0] a_rate,
	input  logic              a_status,
	output int                fail_count,
	output int                pending,
	output int                answers_seen,
	output int                overflow_seen
);

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              status;
	} rate_answer_t;

	logic [31:0] init_r, floor_r;
	logic [30:0] base_r;
	logic [15:0] growth_r;
	logic [16:0] cos_tab [0:COS_TABLE_DEPTH];
	rate_answer_t expected_rates[$];

	function automatic logic [16:0] cos_magnitude(logic [31:0] s);
		logic [63:0] pos, idx, frac;
		logic [16:0] a, b;
		pos  = 64'(s) * COS_TABLE_DEPTH;
		idx  = pos >> 15;
		frac = pos & 64'h7FFF;
		if (idx >= COS_TABLE_DEPTH) return cos_tab[COS_TABLE_DEPTH];
		a = cos_tab[idx];
		b = cos_tab[idx + 1];
		if (a >= b) return a - 17'((64'(a - b) * frac + 64'h4000) >> 15);
		return a + 17'((64'(b - a) * frac + 64'h4000) >> 15);
	endfunction

	function automatic rate_answer_t predict_rate(logic [30:0] epoch);
		rate_answer_t r;
		logic [63:0] rem, t, p, c, diff, off;
		r = '0;
		rem = 64'(epoch);
		t = 64'(base_r);
		if (t == 0) begin
			r.status = 1'b1;
			return r;
		end
		if (growth_r == 1) rem = rem % t;
		else begin
			while (rem >= t) begin
				rem = rem - t;
				t = t * growth_r;
				if (t == 0 || t > 64'h7FFF_FFFF) begin
					r.status = 1'b1;
					return r;
				end
			end
		end
		p = (rem << 16) / t;
		if (p < 64'h8000) c = 64'h10000 + cos_magnitude(32'(p));
		else c = 64'h10000 - cos_magnitude(32'(64'h10000 - p));
		if (init_r >= floor_r) begin
			diff = 64'(init_r) - floor_r;
			off = (diff * c + 64'h10000) >> 17;
			r.rate = 32'(64'(floor_r) + off);
		end else begin
			diff = 64'(floor_r) - init_r;
			off = (diff * c + 64'h10000) >> 17;
			r.rate = 32'(64'(floor_r) - off);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// own copy of the quarter-wave table, same series and rounding
	initial begin
		logic [63:0] x, x2, term, acc, c;
		for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
			x = (64'd1686629713 * 64'(i)) / COS_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			acc = term;
			for (int k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
				if (k % 2) acc = acc - term;
				else acc = acc + term;
			end
			c = acc & 64'hFFFF_FFFF;
			if (c > (64'd1 << 30)) c = 64'd1 << 30;
			cos_tab[i] = 17'((c + (64'd1 << 13)) >> 14);
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		answers_seen = 0;
		overflow_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rate_answer_t want;
		if (!arst_n) begin
			init_r   <= 32'd1 << RATE_FRAC_BITS;
			floor_r  <= '0;
			base_r   <= 31'd1;
			growth_r <= 16'd1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL_RATE: init_r <= cfg_data;
					CFG_FLOOR_RATE: floor_r <= cfg_data;
					CFG_BASE_PERIOD: base_r <= cfg_data[30:0];
					CFG_PERIOD_GROWTH: growth_r <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (q_valid && q_ready) expected_rates.push_back(predict_rate(q_epoch));
			if (a_valid && a_ready) begin
				answers_seen++;
				if (a_status) overflow_seen++;
				if (expected_rates.size() == 0) report_mismatch("answer with no request pending");
				else begin
					want = expected_rates.pop_front();
					if (a_status !== want.status)
						report_mismatch($sformatf("status %0b want %0b", a_status, want.status));
					if (a_rate !== want.rate)
						report_mismatch($sformatf("rate %h want %h", a_rate, want.rate));
				end
			end
			pending = expected_rates.size();
		end
	end

endmodule

>>> verif/cosine_warm_restart_rate_unit_tb.sv
`timescale 1ns / 1ps
module cosine_warm_restart_rate_unit_tb;
	import cwr_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [RATE_W-1:0] cfg_data;
	int                fail_count, pending, answers_seen, overflow_seen;
	int                phases_run;

	cwr_query_if  query();
	cwr_answer_if answer();

	cosine_warm_restart_rate_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .query(query.sink), .answer(answer.source)
	);

	cwr_rate_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_valid(query.valid), .q_ready(query.ready),
		.q_epoch(query.epoch_number), .a_valid(answer.valid), .a_ready(answer.ready),
		.a_rate(answer.learning_rate), .a_status(answer.status),
		.fail_count(fail_count), .pending(pending), .answers_seen(answers_seen),
		.overflow_seen(overflow_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stall pattern: runs of ready high and low, sometimes long stretches of either
	initial begin
		int run;
		answer.ready = 1'b0;
		forever begin
			run = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0) run = 200;
			answer.ready = ($urandom_range(0, 2) != 0);
			repeat (run) @(negedge clk);
		end
	end

	// write one register while the block sits idle
	task automatic write_reg(cfg_index_t idx, logic [RATE_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one request, held until accepted; ready seen at a falling edge holds
	// through the next rising edge, which takes the request
	task automatic send_epoch(logic [EPOCH_W-1:0] epoch);
		query.valid = 1'b1;
		query.epoch_number = epoch;
		while (!query.ready) @(negedge clk);
		@(negedge clk);
		query.valid = 1'b0;
	endtask

	// wait for all answers, then let the block settle before touching config
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic set_config(logic [31:0] init_v, logic [31:0] floor_v,
		logic [31:0] base_v, logic [31:0] growth_v);
		drain();
		write_reg(CFG_INITIAL_RATE, init_v);
		write_reg(CFG_FLOOR_RATE, floor_v);
		write_reg(CFG_BASE_PERIOD, base_v);
		write_reg(CFG_PERIOD_GROWTH, growth_v);
		phases_run++;
	endtask

	// random epoch, biased toward small values and toward values with the top bit set
	function automatic logic [EPOCH_W-1:0] pick_epoch();
		case ($urandom_range(0, 3))
			0: return EPOCH_W'($urandom);
			1: return EPOCH_W'($urandom_range(0, 300));
			2: return EPOCH_W'($urandom_range(0, 100000));
			default: return {1'b1, 30'($urandom)};
		endcase
	endfunction

	initial begin
		int burst;
		phases_run = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_INITIAL_RATE;
		cfg_data = '0;
		query.valid = 1'b0;
		query.epoch_number = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, then extremes of each register
		send_epoch('0);
		send_epoch('1);
		set_config(32'h0100_0000, 32'h0, 32'd10, 32'd1);
		for (int e = 0; e <= 10; e++) send_epoch(EPOCH_W'(e));
		// growth of two: restarts, then overflow at the far end
		set_config(32'hFFFF_FFFF, 32'h0, 32'd7, 32'd2);
		send_epoch(31'd6);
		send_epoch(31'd7);
		send_epoch(31'd20);
		send_epoch(31'd21);
		send_epoch('1);
		// initial below floor, full-scale growth, zero base and zero growth
		set_config(32'h0000_1000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF);
		send_epoch(31'h4000_0000);
		send_epoch('1);
		set_config(32'h0200_0000, 32'h0010_0000, 32'h0, 32'h3);
		send_epoch(31'd5);
		set_config(32'h0200_0000, 32'h0010_0000, 32'd4, 32'h0);
		send_epoch(31'd3);
		send_epoch(31'd4);

		// random phases with bursty sender
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: set_config($urandom, $urandom, $urandom_range(1, 1000), 1);
				1: set_config($urandom, $urandom, $urandom_range(1, 50), $urandom_range(2, 4));
				2: set_config($urandom, $urandom, $urandom, $urandom);
				default: set_config($urandom, 32'h0, 32'($urandom_range(0, 3)) << $urandom_range(0, 30),
					$urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(1, 9));
			endcase
			for (int n = 0; n < 100; ) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst && n < 100; b++, n++) send_epoch(pick_epoch());
				if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end

		drain();
		$display("run covered %0d config phases, %0d answers checked, %0d overflow answers",
			phases_run, answers_seen, overflow_seen);
		if (fail_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#40ms;
		$display("timeout with %0d answers outstanding", pending);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
